/* sv/bipolar_hamming_nearest_prototype_unit_assert.svh */
// Assertion macros shared by the classifier RTL.
`ifndef BIPOLAR_HAMMING_NEAREST_PROTOTYPE_UNIT_ASSERT_SVH
`define BIPOLAR_HAMMING_NEAREST_PROTOTYPE_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define BHNP_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("bhnp assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define BHNP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bhnp assertion failed");

`endif

/* sv/bhnp_pkg.sv */
package bhnp_pkg;

  localparam int NUM_CLASSES = 8;
  localparam int DIMENSIONS  = 2048;
  localparam int LANE_BITS   = 64;

  localparam int CHUNKS   = (DIMENSIONS + LANE_BITS - 1) / LANE_BITS;
  localparam int CHUNK_AW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CLS_W    = $clog2(NUM_CLASSES);
  localparam int CNT_W    = $clog2(NUM_CLASSES + 1);
  localparam int PC_W     = $clog2(LANE_BITS + 1);
  localparam int GROUPS   = (LANE_BITS + 7) / 8;

  // Fixed field widths of the request and result channels.
  localparam int REQ_CLS_W   = 3;
  localparam int REQ_CHUNK_W = 5;
  localparam int SIGN_W      = 64;
  localparam int CFG_W       = 4;
  localparam int RES_CLS_W   = 3;
  localparam int DIST_W      = 12;
  localparam int DIST_MAX    = 4095;

  localparam int ACTIVE_RESET = 8;

  typedef enum logic {
    REQ_LOAD     = 1'b0,
    REQ_CLASSIFY = 1'b1
  } req_type_t;

  typedef logic [DIST_W-1:0] dist_t;
  typedef dist_t [NUM_CLASSES-1:0] dist_vec_t;

  // Control shared by all lanes for one pipeline step.
  typedef struct packed {
    logic                 wr_en;
    logic [CHUNK_AW-1:0]  wr_addr;
    logic [LANE_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [CHUNK_AW-1:0]  rd_addr;
    logic [LANE_BITS-1:0] sample;
    logic                 clear;
    logic                 acc_en;
  } lane_ctl_t;

endpackage

/* sv/bhnp_if.sv */
interface bhnp_req_if;
  import bhnp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [REQ_CLS_W-1:0]   class_index;
  logic [REQ_CHUNK_W-1:0] chunk_index;
  logic [SIGN_W-1:0]      sign_bits;
  logic                   last_chunk;

  modport source (output valid, req_type, class_index, chunk_index, sign_bits, last_chunk,
                  input ready);
  modport sink (input valid, req_type, class_index, chunk_index, sign_bits, last_chunk,
                output ready);
endinterface

interface bhnp_res_if;
  import bhnp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [RES_CLS_W-1:0] predicted_class;
  logic [DIST_W-1:0]    best_distance;

  modport source (output valid, predicted_class, best_distance, input ready);
  modport sink (input valid, predicted_class, best_distance, output ready);
endinterface

/* sv/bhnp_lane.sv */
module bhnp_lane import bhnp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  lane_ctl_t ctl,
  input  logic      wr_sel,
  output dist_t     class_dist
);

  logic [LANE_BITS-1:0] mem [CHUNKS];
  logic [LANE_BITS-1:0] rd_q;
  logic [LANE_BITS-1:0] diff;
  logic [GROUPS*8-1:0]  padded;
  logic [3:0]           grp_cnt [GROUPS];
  logic [PC_W-1:0]      pc;
  dist_t                base;
  logic [DIST_W:0]      sum;
  dist_t                dist_next;

  always_ff @(posedge clk) begin
    if (ctl.wr_en && wr_sel) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[ctl.rd_addr];
    end
  end

  // Popcount in byte groups, then a sum of the group counts.
  always_comb begin
    diff   = rd_q ^ ctl.sample;
    padded = '0;
    padded[LANE_BITS-1:0] = diff;
    for (int g = 0; g < GROUPS; g++) begin
      grp_cnt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        grp_cnt[g] = grp_cnt[g] + 4'(padded[g*8+b]);
      end
    end
    pc = '0;
    for (int g = 0; g < GROUPS; g++) begin
      pc = pc + PC_W'(grp_cnt[g]);
    end
  end

  always_comb begin
    base = ctl.clear ? '0 : class_dist;
    sum  = {1'b0, base} + (DIST_W+1)'(pc);
    dist_next = (sum > (DIST_W+1)'(DIST_MAX)) ? DIST_W'(DIST_MAX) : sum[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      class_dist <= '0;
    end else if (ctl.acc_en) begin
      class_dist <= dist_next;
    end
  end

endmodule

/* sv/bhnp_merge.sv */
module bhnp_merge import bhnp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  dist_vec_t        dist_all,
  input  logic [CNT_W-1:0] active_n,
  input  logic             capture,
  output logic             full,
  bhnp_res_if.source       res
);

  logic [CLS_W-1:0] best_idx;
  dist_t            best_d;

  // Strict less-than keeps the lowest index on ties.
  always_comb begin
    best_idx = '0;
    best_d   = dist_all[0];
    for (int c = 1; c < NUM_CLASSES; c++) begin
      if (c < int'(active_n) && dist_all[c] < best_d) begin
        best_d   = dist_all[c];
        best_idx = CLS_W'(c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (capture) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      res.predicted_class <= RES_CLS_W'(best_idx);
      res.best_distance   <= best_d;
    end
  end

  assign full = res.valid && !res.ready;

endmodule

/* sv/bipolar_hamming_nearest_prototype_unit.sv */
// A last classify chunk passes stage one, the distance registers and then the output register.
// Throughput: one request per cycle while ready, set by the per-lane RAM read and popcount-accumulate step.
// A request is refused only while a result waits in the output register and another is due.
// Reset (rst, synchronous, active high) clears the pipeline, the class distances and the
// output valid, and sets active_classes to 8; the prototype RAMs are not cleared.
`include "bipolar_hamming_nearest_prototype_unit_assert.svh"

module bipolar_hamming_nearest_prototype_unit import bhnp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  bhnp_req_if.sink         req,
  bhnp_res_if.source       res
);

  // The configuration register holds the raw value; the clamp below maps zero to
  // one and anything above the class count down to the class count.
  logic [CFG_W-1:0] active_classes;
  logic [CNT_W-1:0] active_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_classes <= CFG_W'(ACTIVE_RESET);
    end else if (cfg_we) begin
      active_classes <= cfg_wdata;
    end
  end

  always_comb begin
    if (active_classes == '0) begin
      active_n = CNT_W'(1);
    end else if (int'(active_classes) > NUM_CLASSES) begin
      active_n = CNT_W'(NUM_CLASSES);
    end else begin
      active_n = CNT_W'(active_classes);
    end
  end

  // Pipeline control. Stage one holds a classify request while every lane reads its
  // prototype chunk. Stage two marks that the distances just updated belong to a last
  // chunk, so the merge stage captures a result unless the output register is full. Everything moves
  // together; the only stall is a due result that meets a full output register.
  logic                 full;
  logic                 res_pend;
  logic                 stall;
  logic                 advance;
  logic                 accept;
  logic                 is_classify;
  logic                 s1_valid;
  logic                 s1_first;
  logic                 s1_last;
  logic                 s1_range;
  logic [LANE_BITS-1:0] s1_sample;
  logic                 capture;
  lane_ctl_t            ctl;
  dist_vec_t            dist_all;

  assign stall       = res_pend && full;
  assign advance     = !stall;
  assign req.ready   = advance;
  assign accept      = req.valid && req.ready;
  assign is_classify = (req.req_type == REQ_CLASSIFY);
  assign capture     = res_pend && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      res_pend <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept && is_classify;
      res_pend <= s1_valid && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_first  <= (req.chunk_index == '0);
      s1_last   <= req.last_chunk;
      s1_range  <= (int'(req.chunk_index) < CHUNKS);
      s1_sample <= req.sign_bits[LANE_BITS-1:0];
    end
  end

  // Loads write straight into the selected lane's RAM at acceptance; a classify
  // request accepted in the next cycle already reads the new word.
  always_comb begin
    ctl.wr_en   = accept && !is_classify && (int'(req.chunk_index) < CHUNKS);
    ctl.wr_addr = CHUNK_AW'(req.chunk_index);
    ctl.wr_data = req.sign_bits[LANE_BITS-1:0];
    ctl.rd_en   = advance;
    ctl.rd_addr = CHUNK_AW'(req.chunk_index);
    ctl.sample  = s1_sample;
    ctl.clear   = s1_first;
    ctl.acc_en  = advance && s1_valid && s1_range;
  end

  // One lane per class: prototype RAM, popcount of the mismatch and the distance counter.
  for (genvar i = 0; i < NUM_CLASSES; i++) begin : g_lane
    logic wr_sel;
    assign wr_sel = (int'(req.class_index) == i);

    bhnp_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .wr_sel     (wr_sel),
      .class_dist (dist_all[i])
    );
  end

  // The merge stage picks the nearest active class and holds it in the output register.
  bhnp_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .dist_all (dist_all),
    .active_n (active_n),
    .capture  (capture),
    .full     (full),
    .res      (res)
  );

  // Distances change only when a classify request in range moves out of stage one.
  `BHNP_ASSERT_NEXT(a_dist_hold, clk, rst, !ctl.acc_en, $stable(dist_all))
  // A new result appears only after a last chunk has finished accumulating.
  `BHNP_ASSERT_ALWAYS(a_res_origin, clk, rst, !$rose(res.valid) || $past(res_pend))
  // The reported class always lies within the active class range.
  `BHNP_ASSERT_ALWAYS(a_class_range, clk, rst,
                      !res.valid || ({1'b0, res.predicted_class} < (RES_CLS_W+1)'(active_n)))

endmodule

/* tb/sv/bipolar_hamming_nearest_prototype_unit_test.sv */
module bipolar_hamming_nearest_prototype_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bhnp_pkg::*;

  // Cycles allowed for the pipeline to empty before a register write or the final verdict.
  localparam int DRAIN_CYCLES  = 12;
  // Watchdog bound, several times the slowest correct run.
  localparam int LIMIT_CYCLES  = 400000;
  // Length of the long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 120;
  localparam int DIRECTED_ROWS = 17;

  localparam logic [SIGN_W-1:0] LANE_MASK = {SIGN_W{1'b1}} >> (SIGN_W - LANE_BITS);

  // One request as it travels on the request channel.
  typedef struct packed {
    req_type_t              kind;
    logic [REQ_CLS_W-1:0]   cls;
    logic [REQ_CHUNK_W-1:0] chunk;
    logic [SIGN_W-1:0]      bits;
    logic                   last;
  } request_t;

  // One classification result: winning class and its Hamming distance.
  typedef struct packed {
    logic [RES_CLS_W-1:0] cls;
    logic [DIST_W-1:0]    distance;
  } vote_t;

  // A row of the directed table. When typed is set, vote is the result read straight
  // off the behavior; otherwise the predictor supplies the expected result.
  typedef struct packed {
    request_t req;
    logic     typed;
    vote_t    vote;
  } directed_row_t;

  // How a sample chunk is derived from the prototypes.
  typedef enum int {
    SAMPLE_NEAR,
    SAMPLE_INVERTED,
    SAMPLE_NOISE
  } sample_flavor_t;

  // How chunk indexes advance within a sample.
  typedef enum int {
    WALK_SEQ,
    WALK_MIXED,
    WALK_SCATTER
  } chunk_walk_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  bhnp_req_if req_ch ();
  bhnp_res_if res_ch ();

  bipolar_hamming_nearest_prototype_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  // Shadow copy of the block's state, kept in step with every accepted request.
  logic [LANE_BITS-1:0] prototype_copy [NUM_CLASSES][CHUNKS];
  logic [DIST_W-1:0]    distance_copy  [NUM_CLASSES];
  logic [CFG_W-1:0]     active_copy;

  // Results still owed by the block, oldest first.
  vote_t expected_votes [$];

  int requests_sent;
  int mismatch_count;
  int cycle_count;

  // Knobs shared between the request driver and the result receiver.
  bit sender_idle_on;
  bit receiver_idle_on;
  bit stall_request;

  // The directed part. Prototypes are all zero when this table starts, so until the first
  // load the distances of the typed rows are plain popcounts of the sample bits.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // All distances zero: the tie goes to class 0.
    '{'{REQ_CLASSIFY, 3'd0, 5'd0, 64'h0000_0000_0000_0000, 1'b1}, 1'b1, '{3'd0, 12'd0}},
    // Every bit mismatches in every class; still a tie at 64.
    '{'{REQ_CLASSIFY, 3'd7, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1}, 1'b1, '{3'd0, 12'd64}},
    // A load with last_chunk set must not produce a result.
    '{'{REQ_LOAD,     3'd7, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1}, 1'b0, '{3'd0, 12'd0}},
    '{'{REQ_CLASSIFY, 3'd2, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1}, 1'b1, '{3'd7, 12'd0}},
    '{'{REQ_LOAD,     3'd7, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0}, 1'b0, '{3'd0, 12'd0}},
    // Two-chunk sample, first and last chunk index.
    '{'{REQ_CLASSIFY, 3'd1, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0}, 1'b0, '{3'd0, 12'd0}},
    '{'{REQ_CLASSIFY, 3'd6, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1}, 1'b1, '{3'd7, 12'd0}},
    // Lowest and highest sign bit alone.
    '{'{REQ_CLASSIFY, 3'd3, 5'd0, 64'h0000_0000_0000_0001, 1'b1}, 1'b1, '{3'd0, 12'd1}},
    '{'{REQ_CLASSIFY, 3'd4, 5'd0, 64'h8000_0000_0000_0000, 1'b1}, 1'b1, '{3'd0, 12'd1}},
    '{'{REQ_LOAD,     3'd3, 5'd5, 64'hFFFF_0000_0000_0000, 1'b0}, 1'b0, '{3'd0, 12'd0}},
    // Chunk 0 in the middle of nowhere restarts the distances.
    '{'{REQ_CLASSIFY, 3'd5, 5'd0, 64'h0000_0000_0000_0000, 1'b0}, 1'b0, '{3'd0, 12'd0}},
    '{'{REQ_CLASSIFY, 3'd0, 5'd5, 64'hFFFF_0000_0000_0000, 1'b0}, 1'b0, '{3'd0, 12'd0}},
    // The same chunk twice accumulates twice.
    '{'{REQ_CLASSIFY, 3'd0, 5'd5, 64'hFFFF_0000_0000_0000, 1'b1}, 1'b0, '{3'd0, 12'd0}},
    // A sample that continues without a fresh chunk 0.
    '{'{REQ_CLASSIFY, 3'd2, 5'd7, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0}, 1'b0, '{3'd0, 12'd0}},
    '{'{REQ_CLASSIFY, 3'd5, 5'd31, 64'h5555_5555_5555_5555, 1'b1}, 1'b0, '{3'd0, 12'd0}},
    '{'{REQ_LOAD,     3'd0, 5'd0, 64'hFFFF_FFFF_0000_0000, 1'b0}, 1'b0, '{3'd0, 12'd0}},
    '{'{REQ_CLASSIFY, 3'd1, 5'd0, 64'hFFFF_FFFF_0000_0000, 1'b1}, 1'b1, '{3'd0, 12'd0}}
  };

  // Updates the shadow state with one accepted request. Returns 1 and the vote when
  // the request is the last chunk of a classified sample.
  function automatic bit score_request(input request_t r, output vote_t v);
    logic [SIGN_W-1:0] lane;
    int sum;
    int n;
    lane = r.bits & LANE_MASK;
    v = '0;
    if (r.kind == REQ_LOAD) begin
      if (r.cls < NUM_CLASSES && r.chunk < CHUNKS) begin
        prototype_copy[r.cls][r.chunk] = LANE_BITS'(lane);
      end
      return 1'b0;
    end
    // A sample starts over at chunk 0.
    if (r.chunk == 0) begin
      for (int c = 0; c < NUM_CLASSES; c++) distance_copy[c] = '0;
    end
    if (r.chunk < CHUNKS) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        sum = int'(distance_copy[c]) +
              $countones(lane ^ SIGN_W'(prototype_copy[c][r.chunk]));
        distance_copy[c] = (sum > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(sum);
      end
    end
    if (!r.last) return 1'b0;
    // Zero active classes behaves as one; anything beyond the store as all of it.
    n = int'(active_copy);
    if (n == 0) n = 1;
    if (n > NUM_CLASSES) n = NUM_CLASSES;
    v.cls      = '0;
    v.distance = distance_copy[0];
    for (int c = 1; c < n; c++) begin
      if (distance_copy[c] < v.distance) begin
        v.cls      = RES_CLS_W'(c);
        v.distance = distance_copy[c];
      end
    end
    return 1'b1;
  endfunction

  // Offers one request and waits for the handshake. An idle burst may go in front of the
  // request while sender idling is on. The expected result is queued at acceptance.
  task automatic offer_request(input request_t r, input bit typed, input vote_t typed_vote);
    vote_t predicted;
    bit gives;
    if (sender_idle_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= r.kind;
    req_ch.class_index <= r.cls;
    req_ch.chunk_index <= r.chunk;
    req_ch.sign_bits   <= r.bits;
    req_ch.last_chunk  <= r.last;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    gives = score_request(r, predicted);
    if (gives) expected_votes.push_back(typed ? typed_vote : predicted);
    requests_sent++;
  endtask

  function automatic request_t random_load();
    request_t r;
    r.kind  = REQ_LOAD;
    r.cls   = REQ_CLS_W'($urandom);
    r.chunk = REQ_CHUNK_W'($urandom);
    r.bits  = {$urandom, $urandom};
    r.last  = 1'($urandom);
    return r;
  endfunction

  // Sends one sample of len chunks. Near samples copy the target prototype with a
  // sparse set of flipped bits, so the winner and the ties vary from sample to sample.
  task automatic send_sample(input int target, input int len, input bit from_zero,
                             input sample_flavor_t flavor, input chunk_walk_t walk);
    request_t r;
    logic [SIGN_W-1:0] flips;
    int chunk;
    chunk = 0;
    for (int k = 0; k < len; k++) begin
      if (k == 0) begin
        chunk = from_zero ? 0 : $urandom_range(0, CHUNKS - 1);
      end else if (walk == WALK_SCATTER) begin
        // Long samples never revisit chunk 0, so the distances can run into saturation.
        chunk = $urandom_range(1, CHUNKS - 1);
      end else if (walk == WALK_MIXED && $urandom_range(0, 3) == 0) begin
        chunk = $urandom_range(0, CHUNKS - 1);
      end else begin
        chunk = (chunk + 1) % CHUNKS;
      end
      // Now and then a prototype slice is rewritten in the middle of a sample.
      if (walk != WALK_SEQ && $urandom_range(0, 9) == 0) offer_request(random_load(), 1'b0, '0);
      flips = {$urandom, $urandom};
      repeat ($urandom_range(0, 4)) flips &= {$urandom, $urandom};
      if ($urandom_range(0, 5) == 0) flips = '0;
      r.kind  = REQ_CLASSIFY;
      r.cls   = REQ_CLS_W'($urandom);
      r.chunk = REQ_CHUNK_W'(chunk);
      r.last  = (k == len - 1);
      case (flavor)
        SAMPLE_NEAR:     r.bits = SIGN_W'(prototype_copy[target][chunk]) ^ flips;
        SAMPLE_INVERTED: r.bits = ~SIGN_W'(prototype_copy[target][chunk]);
        default:         r.bits = {$urandom, $urandom};
      endcase
      offer_request(r, 1'b0, '0);
    end
  endtask

  // Stops offering, waits for every owed result and lets the pipeline empty.
  task automatic settle_block();
    req_ch.valid <= 1'b0;
    while (expected_votes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_active_classes(input logic [CFG_W-1:0] value);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_copy = value;
  endtask

  // Compares one accepted result with the oldest expectation, field by field.
  task automatic check_vote();
    vote_t want;
    if (expected_votes.size() == 0) begin
      $error("unexpected result: predicted_class %0d best_distance %0d",
             res_ch.predicted_class, res_ch.best_distance);
      mismatch_count++;
    end else begin
      want = expected_votes.pop_front();
      if (res_ch.predicted_class !== want.cls) begin
        $error("predicted_class: expected %0d, actual %0d", want.cls, res_ch.predicted_class);
        mismatch_count++;
      end
      if (res_ch.best_distance !== want.distance) begin
        $error("best_distance: expected %0d, actual %0d", want.distance,
               res_ch.best_distance);
        mismatch_count++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a run that has not finished by the limit counts as failed.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("bipolar_hamming_nearest_prototype_unit: mismatch");
    $finish;
  end

  // Result receiver. Ready is decided ahead of each edge and results are checked at the
  // edge where valid and ready are both high. A stall request from the stimulus turns
  // into one long hold-off, counted here, so that the block fills up behind it.
  initial begin
    int idle_left;
    int hold_left;
    idle_left = 0;
    hold_left = 0;
    forever begin
      if (stall_request) begin
        hold_left     = HOLD_CYCLES;
        stall_request = 1'b0;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (idle_left > 0) begin
        res_ch.ready <= 1'b0;
        idle_left--;
      end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        idle_left = $urandom_range(1, 17) - 1;
      end else begin
        res_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) check_vote();
    end
  end

  // Stimulus: reset, a zero fill of the prototype store, the directed table, a random
  // refill, then random phases at several class counts.
  initial begin
    request_t r;
    logic [CFG_W-1:0] cfg;
    int phase_start;
    int pick;

    requests_sent    = 0;
    mismatch_count   = 0;
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    stall_request    = 1'b0;
    active_copy      = CFG_W'(ACTIVE_RESET);
    for (int c = 0; c < NUM_CLASSES; c++) distance_copy[c] = '0;

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_LOAD;
    req_ch.class_index <= '0;
    req_ch.chunk_index <= '0;
    req_ch.sign_bits   <= '0;
    req_ch.last_chunk  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // The store is undefined after reset, so every entry is written before any classify.
    for (int c = 0; c < NUM_CLASSES; c++) begin
      for (int k = 0; k < CHUNKS; k++) begin
        r = '{REQ_LOAD, REQ_CLS_W'(c), REQ_CHUNK_W'(k), '0, 1'b0};
        offer_request(r, 1'b0, '0);
      end
    end

    // Directed part, run at the reset class count.
    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].vote);
    end

    // Random prototypes. Some slices copy the previous class so that ties come up.
    for (int c = 0; c < NUM_CLASSES; c++) begin
      for (int k = 0; k < CHUNKS; k++) begin
        r = random_load();
        r.cls   = REQ_CLS_W'(c);
        r.chunk = REQ_CHUNK_W'(k);
        if (c > 0 && $urandom_range(0, 3) == 0) r.bits = SIGN_W'(prototype_copy[c - 1][k]);
        offer_request(r, 1'b0, '0);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       cfg = CFG_W'(1);
        1:       cfg = CFG_W'(0);
        2:       cfg = {CFG_W{1'b1}};
        3:       cfg = CFG_W'(NUM_CLASSES);
        default: cfg = CFG_W'($urandom_range(1, NUM_CLASSES));
      endcase
      set_active_classes(cfg);
      // The closing phase runs with both sides at full rate.
      sender_idle_on   = (p != PHASES - 1) && (p == 0 || $urandom_range(0, 3) != 0);
      receiver_idle_on = (p != PHASES - 1) && (p == 0 || $urandom_range(0, 3) != 0);
      phase_start = requests_sent;

      if (p == 0) begin
        // Only class 0 takes part; the inverted sample drives its distance to saturation.
        send_sample(0, $urandom_range(70, 100), 1'b1, SAMPLE_INVERTED, WALK_SCATTER);
      end
      if (p == 2) begin
        // Results pile up behind the long hold-off while requests keep coming.
        stall_request = 1'b1;
        repeat (24) send_sample($urandom_range(0, NUM_CLASSES - 1), 1, 1'b1,
                                SAMPLE_NEAR, WALK_SEQ);
      end

      while (requests_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          send_sample($urandom_range(0, NUM_CLASSES - 1), $urandom_range(1, 6), 1'b1,
                      ($urandom_range(0, 4) == 0) ? SAMPLE_NOISE : SAMPLE_NEAR, WALK_MIXED);
        end else if (pick < 63) begin
          send_sample($urandom_range(0, NUM_CLASSES - 1), CHUNKS, 1'b1, SAMPLE_NEAR, WALK_SEQ);
        end else if (pick < 65) begin
          // Random bits over a long sample can saturate every class.
          send_sample(0, $urandom_range(64, 140), 1'b1, SAMPLE_NOISE, WALK_SCATTER);
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 4)) offer_request(random_load(), 1'b0, '0);
        end else begin
          // Stray chunks with no proper start and a random end of sample.
          repeat ($urandom_range(1, 3)) begin
            r.kind  = REQ_CLASSIFY;
            r.cls   = REQ_CLS_W'($urandom);
            r.chunk = REQ_CHUNK_W'($urandom);
            r.bits  = {$urandom, $urandom};
            r.last  = ($urandom_range(0, 2) == 0);
            offer_request(r, 1'b0, '0);
          end
        end
      end
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("bipolar_hamming_nearest_prototype_unit: match");
    end else begin
      $display("bipolar_hamming_nearest_prototype_unit: mismatch");
    end
    $finish;
  end

endmodule
